### rtl/mpsq_pkg.sv
// Shared types, constants and control-word layout of the minimum priority slot queue.
`default_nettype none

package mpsq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int STEP_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_IN,
    JC_DISPATCH,
    JC_FULL,
    JC_EMPTY,
    JC_SLOT_BUSY,
    JC_NOT_LAST,
    JC_OUT_BUSY
  } jump_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_START,
    A_ENQ_WR,
    A_ENQ_LAST,
    A_SET_FULL,
    A_DEQ_POP,
    A_SCAN_RD,
    A_SET_EMPTY,
    A_CLEAR,
    A_LOAD_OUT
  } act_e;

  typedef enum logic [1:0] {
    SC_HOLD,
    SC_ZERO,
    SC_INC,
    SC_FIND
  } scan_e;

  typedef struct packed {
    jump_e             jmp;
    logic [STEP_W-1:0] target;
    logic              in_ready;
    act_e              act;
    scan_e             scan;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    op_e  op;
    logic full;
    logic empty;
    logic slot_busy;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/mpsq_in_if.sv
// Request channel: operation and value with valid/ready handshake.
`default_nettype none

interface mpsq_in_if;
  logic                         valid;
  logic                         ready;
  logic [mpsq_pkg::OP_W-1:0]    operation;
  logic [mpsq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

### rtl/mpsq_out_if.sv
// Response channel: result value, status and flags with valid/ready handshake.
`default_nettype none

interface mpsq_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpsq_pkg::VALUE_W-1:0]  result_value;
  logic [mpsq_pkg::STATUS_W-1:0] status;
  logic                          now_empty;
  logic                          now_full;

  modport source (output valid, output result_value, output status, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input result_value, input status, input now_empty,
                  input now_full, output ready);
endinterface

`default_nettype wire

### rtl/mpsq_sequencer.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
`default_nettype none

module mpsq_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpsq_pkg::dp_stat_t stat_i,
  output mpsq_pkg::ctrl_t    ctrl_o
);
  import mpsq_pkg::*;

  localparam logic [STEP_W-1:0] U_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] U_DISP     = 4'd1;
  localparam logic [STEP_W-1:0] U_ENQ      = 4'd2;
  localparam logic [STEP_W-1:0] U_ENQ2     = 4'd3;
  localparam logic [STEP_W-1:0] U_FIND     = 4'd4;
  localparam logic [STEP_W-1:0] U_ENQ_WR   = 4'd5;
  localparam logic [STEP_W-1:0] U_ENQ_LAST = 4'd6;
  localparam logic [STEP_W-1:0] U_FULL     = 4'd7;
  localparam logic [STEP_W-1:0] U_DEQ      = 4'd8;
  localparam logic [STEP_W-1:0] U_DEQ_POP  = 4'd9;
  localparam logic [STEP_W-1:0] U_DEQ_CHK  = 4'd10;
  localparam logic [STEP_W-1:0] U_SCAN     = 4'd11;
  localparam logic [STEP_W-1:0] U_SCAN_END = 4'd12;
  localparam logic [STEP_W-1:0] U_EMPTY    = 4'd13;
  localparam logic [STEP_W-1:0] U_CLR      = 4'd14;
  localparam logic [STEP_W-1:0] U_RESP     = 4'd15;  // falls through, wrapping to idle

  function automatic ctrl_t cw(input jump_e j, input logic [STEP_W-1:0] t, input logic r,
                               input act_e a, input scan_e s);
    ctrl_t w;
    w.jmp      = j;
    w.target   = t;
    w.in_ready = r;
    w.act      = a;
    w.scan     = s;
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t w;
    case (s)
      U_IDLE:     w = cw(JC_NO_IN,     U_IDLE,     1'b1, A_NONE,      SC_HOLD);
      U_DISP:     w = cw(JC_DISPATCH,  U_IDLE,     1'b0, A_START,     SC_HOLD);
      U_ENQ:      w = cw(JC_FULL,      U_FULL,     1'b0, A_NONE,      SC_HOLD);
      U_ENQ2:     w = cw(JC_EMPTY,     U_ENQ_LAST, 1'b0, A_NONE,      SC_ZERO);
      U_FIND:     w = cw(JC_SLOT_BUSY, U_FIND,     1'b0, A_NONE,      SC_FIND);
      U_ENQ_WR:   w = cw(JC_ALWAYS,    U_RESP,     1'b0, A_ENQ_WR,    SC_HOLD);
      U_ENQ_LAST: w = cw(JC_ALWAYS,    U_RESP,     1'b0, A_ENQ_LAST,  SC_HOLD);
      U_FULL:     w = cw(JC_ALWAYS,    U_RESP,     1'b0, A_SET_FULL,  SC_HOLD);
      U_DEQ:      w = cw(JC_EMPTY,     U_EMPTY,    1'b0, A_NONE,      SC_HOLD);
      U_DEQ_POP:  w = cw(JC_NEXT,      U_IDLE,     1'b0, A_DEQ_POP,   SC_ZERO);
      U_DEQ_CHK:  w = cw(JC_EMPTY,     U_RESP,     1'b0, A_NONE,      SC_HOLD);
      U_SCAN:     w = cw(JC_NOT_LAST,  U_SCAN,     1'b0, A_SCAN_RD,   SC_INC);
      U_SCAN_END: w = cw(JC_ALWAYS,    U_RESP,     1'b0, A_NONE,      SC_HOLD);
      U_EMPTY:    w = cw(JC_ALWAYS,    U_RESP,     1'b0, A_SET_EMPTY, SC_HOLD);
      U_CLR:      w = cw(JC_ALWAYS,    U_RESP,     1'b0, A_CLEAR,     SC_HOLD);
      U_RESP:     w = cw(JC_OUT_BUSY,  U_RESP,     1'b0, A_LOAD_OUT,  SC_HOLD);
      default:    w = cw(JC_ALWAYS,    U_IDLE,     1'b0, A_NONE,      SC_HOLD);
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch(input op_e op);
    logic [STEP_W-1:0] t;
    case (op)
      OP_ENQUEUE: t = U_ENQ;
      OP_DEQUEUE: t = U_DEQ;
      OP_CLEAR:   t = U_CLR;
      default:    t = U_RESP;
    endcase
    return t;
  endfunction

  logic [STEP_W-1:0] step_q, step_d, step_inc;
  ctrl_t             cur;

  assign cur      = ucode(step_q);
  assign ctrl_o   = cur;
  assign step_inc = step_q + STEP_W'(1);

  always_comb begin
    case (cur.jmp)
      JC_NEXT:      step_d = step_inc;
      JC_ALWAYS:    step_d = cur.target;
      JC_NO_IN:     step_d = stat_i.in_valid  ? step_inc : cur.target;
      JC_DISPATCH:  step_d = dispatch(stat_i.op);
      JC_FULL:      step_d = stat_i.full      ? cur.target : step_inc;
      JC_EMPTY:     step_d = stat_i.empty     ? cur.target : step_inc;
      JC_SLOT_BUSY: step_d = stat_i.slot_busy ? cur.target : step_inc;
      JC_NOT_LAST:  step_d = stat_i.scan_last ? step_inc : cur.target;
      JC_OUT_BUSY:  step_d = stat_i.out_busy  ? cur.target : step_inc;
      default:      step_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= U_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

### rtl/mpsq_datapath.sv
// Datapath: slot store, valid bits, count, minimum tracking, scan unit and result register.
`default_nettype none

module mpsq_datapath #(
  parameter int CAPACITY   = mpsq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = mpsq_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpsq_pkg::ctrl_t               ctrl_i,
  input  logic                          in_valid_i,
  input  logic [mpsq_pkg::OP_W-1:0]     in_operation_i,
  input  logic [mpsq_pkg::VALUE_W-1:0]  in_value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mpsq_pkg::VALUE_W-1:0]  out_result_value_o,
  output logic [mpsq_pkg::STATUS_W-1:0] out_status_o,
  output logic                          out_now_empty_o,
  output logic                          out_now_full_o,
  output mpsq_pkg::dp_stat_t            stat_o
);
  import mpsq_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(CAPACITY);

  logic [VALUE_BITS-1:0] slot_mem_q [CAPACITY];
  logic [CAPACITY-1:0]   valid_q;
  logic [CNT_W-1:0]      count_q;
  logic [SLOT_W-1:0]     scan_q;
  logic [SLOT_W-1:0]     min_slot_q;
  logic [VALUE_BITS-1:0] min_val_q;
  logic                  found_q;
  logic [VALUE_BITS-1:0] rd_q;
  logic                  pend_q;
  logic [SLOT_W-1:0]     idx_q;
  op_e                   op_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] result_q;
  status_e               status_q;

  logic                  out_valid_q;
  logic [VALUE_W-1:0]    out_result_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_empty_q;
  logic                  out_full_q;

  logic in_fire, out_free, out_load, cmp_take, enq_less, is_empty, is_full;

  assign in_fire  = in_valid_i && ctrl_i.in_ready;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (ctrl_i.act == A_LOAD_OUT) && out_free;
  assign cmp_take = pend_q && (!found_q || (rd_q < min_val_q));
  assign enq_less = val_q < min_val_q;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == FULL_COUNT);

  assign stat_o.in_valid  = in_valid_i;
  assign stat_o.op        = op_q;
  assign stat_o.full      = is_full;
  assign stat_o.empty     = is_empty;
  assign stat_o.slot_busy = valid_q[scan_q];
  assign stat_o.scan_last = (scan_q == LAST_SLOT);
  assign stat_o.out_busy  = !out_free;

  assign out_valid_o        = out_valid_q;
  assign out_result_value_o = out_result_q;
  assign out_status_o       = out_status_q;
  assign out_now_empty_o    = out_empty_q;
  assign out_now_full_o     = out_full_q;

  // slot store: one write port, one registered read port for the rescan
  always_ff @(posedge clk_i) begin
    if (ctrl_i.act == A_ENQ_WR) begin
      slot_mem_q[scan_q] <= val_q;
    end else if (ctrl_i.act == A_ENQ_LAST) begin
      slot_mem_q[LAST_SLOT] <= val_q;
    end
    if (ctrl_i.act == A_SCAN_RD) begin
      rd_q  <= slot_mem_q[scan_q];
      idx_q <= scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      min_slot_q  <= LAST_SLOT;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctrl_i.scan)
        SC_ZERO: scan_q <= '0;
        SC_INC:  scan_q <= scan_q + SLOT_W'(1);
        SC_FIND: begin
          if (valid_q[scan_q]) begin
            scan_q <= scan_q + SLOT_W'(1);
          end
        end
        default: ;
      endcase

      pend_q <= (ctrl_i.act == A_SCAN_RD) && valid_q[scan_q];

      if (cmp_take) begin
        min_slot_q <= idx_q;
        found_q    <= 1'b1;
      end

      case (ctrl_i.act)
        A_ENQ_WR: begin
          valid_q[scan_q] <= 1'b1;
          count_q         <= count_q + CNT_W'(1);
          if (enq_less) begin
            min_slot_q <= scan_q;
          end
        end
        A_ENQ_LAST: begin
          valid_q[LAST_SLOT] <= 1'b1;
          count_q            <= CNT_W'(1);
          min_slot_q         <= LAST_SLOT;
        end
        A_DEQ_POP: begin
          valid_q[min_slot_q] <= 1'b0;
          count_q             <= count_q - CNT_W'(1);
          min_slot_q          <= LAST_SLOT;
          found_q             <= 1'b0;
        end
        A_CLEAR: begin
          valid_q    <= '0;
          count_q    <= '0;
          min_slot_q <= LAST_SLOT;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(in_operation_i);
      val_q <= VALUE_BITS'(in_value_i);
    end

    if (cmp_take) begin
      min_val_q <= rd_q;
    end

    case (ctrl_i.act)
      A_START: begin
        result_q <= '0;
        status_q <= ST_OK;
      end
      A_ENQ_WR: begin
        if (enq_less) begin
          min_val_q <= val_q;
        end
      end
      A_ENQ_LAST:  min_val_q <= val_q;
      A_SET_FULL:  status_q  <= ST_FULL;
      A_DEQ_POP:   result_q  <= min_val_q;
      A_SET_EMPTY: status_q  <= ST_EMPTY;
      default: ;
    endcase

    if (out_load) begin
      out_result_q <= VALUE_W'(result_q);
      out_status_q <= status_q;
      out_empty_q  <= is_empty;
      out_full_q   <= is_full;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("held count out of step with valid bits");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == A_DEQ_POP) |-> (!is_empty && valid_q[min_slot_q]))
    else $error("dequeue of an empty queue or invalid minimum slot");

  a_enq_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == A_ENQ_WR) |-> (!valid_q[scan_q] && !is_full))
    else $error("enqueue writes an occupied slot");

  a_min_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl_i.act == A_LOAD_OUT) && !is_empty) |-> valid_q[min_slot_q])
    else $error("minimum slot not valid at end of transaction");

endmodule

`default_nettype wire

### rtl/min_priority_slot_queue.sv
// Top level of the minimum priority slot queue: sequencer plus datapath.
// Usage: one request per transaction on in_i (operation: enqueue, dequeue minimum,
// clear; value for enqueue). Each request yields exactly one response on out_o with
// the removed minimum (zero otherwise), a status code (ok, full, empty) and the
// empty/full flags as they stand after the access.
// A microcoded sequencer runs each request to completion, one at a time; in_i.ready
// is high only in the idle step. An enqueue into an empty queue writes the last slot;
// other enqueues (unless full) search upward from slot 0 for the lowest free slot.
// A dequeue that leaves values behind rescans every slot for the new minimum, reading
// the slot memory one entry per cycle through its single registered read port.
// The response sits in an output register; the next request is accepted while it
// waits. If out_o.ready stays low, the following request stalls in its final step.
// Reset empties the queue at once (valid bits cleared) and drops any pending response.
`default_nettype none

module min_priority_slot_queue #(
  parameter int CAPACITY   = mpsq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = mpsq_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpsq_in_if.sink    in_i,
  mpsq_out_if.source out_o
);
  import mpsq_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;

  assign in_i.ready = ctrl.in_ready;

  mpsq_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mpsq_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .in_valid_i         (in_i.valid),
    .in_operation_i     (in_i.operation),
    .in_value_i         (in_i.value),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_result_value_o (out_o.result_value),
    .out_status_o       (out_o.status),
    .out_now_empty_o    (out_o.now_empty),
    .out_now_full_o     (out_o.now_full),
    .stat_o             (stat)
  );

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the minimum priority slot queue: directed table, then random traffic.
`default_nettype none

module testbench;
  import mpsq_pkg::*;

  localparam int SLOTS           = CAPACITY_DEF;
  localparam int LAST_SLOT       = SLOTS - 1;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 200;

  typedef struct packed {
    logic [VALUE_W-1:0] result_value;
    status_e            status;
    logic               now_empty;
    logic               now_full;
  } resp_t;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic               typed;
    resp_t              exp;
  } row_t;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED,
    MODE_NOISE
  } traffic_e;

  typedef enum int {
    VAL_FULL_RANGE,
    VAL_NARROW,
    VAL_EXTREMES
  } value_style_e;

  localparam resp_t NO_CHECK = '{16'h0000, ST_OK, 1'b0, 1'b0};
  localparam int    SCRIPT_LEN = 22;

  // typed rows carry their own expected response
  row_t script [SCRIPT_LEN] = '{
    '{OP_DEQUEUE, 16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 1'b1, 1'b0}},
    '{OP_NOP,     16'hFFFF, 1'b1, '{16'h0000, ST_OK,    1'b1, 1'b0}},
    '{OP_CLEAR,   16'h0000, 1'b1, '{16'h0000, ST_OK,    1'b1, 1'b0}},
    '{OP_ENQUEUE, 16'hFFFF, 1'b1, '{16'h0000, ST_OK,    1'b0, 1'b0}},
    '{OP_DEQUEUE, 16'h0000, 1'b1, '{16'hFFFF, ST_OK,    1'b1, 1'b0}},
    '{OP_ENQUEUE, 16'h1234, 1'b0, NO_CHECK},
    '{OP_ENQUEUE, 16'h1234, 1'b0, NO_CHECK},
    '{OP_ENQUEUE, 16'h0000, 1'b0, NO_CHECK},
    '{OP_ENQUEUE, 16'hFFFF, 1'b0, NO_CHECK},
    '{OP_ENQUEUE, 16'h8000, 1'b0, NO_CHECK},
    '{OP_NOP,     16'hAAAA, 1'b0, NO_CHECK},
    '{OP_DEQUEUE, 16'h5555, 1'b1, '{16'h0000, ST_OK,    1'b0, 1'b0}},
    '{OP_DEQUEUE, 16'h0000, 1'b0, NO_CHECK},
    '{OP_DEQUEUE, 16'hFFFF, 1'b0, NO_CHECK},
    '{OP_ENQUEUE, 16'h0001, 1'b0, NO_CHECK},
    '{OP_CLEAR,   16'hFFFF, 1'b1, '{16'h0000, ST_OK,    1'b1, 1'b0}},
    '{OP_DEQUEUE, 16'h0000, 1'b1, '{16'h0000, ST_EMPTY, 1'b1, 1'b0}},
    '{OP_ENQUEUE, 16'h0007, 1'b0, NO_CHECK},
    '{OP_ENQUEUE, 16'h0007, 1'b0, NO_CHECK},
    '{OP_ENQUEUE, 16'h0003, 1'b0, NO_CHECK},
    '{OP_DEQUEUE, 16'h0000, 1'b0, NO_CHECK},
    '{OP_CLEAR,   16'h0000, 1'b1, '{16'h0000, ST_OK,    1'b1, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  mpsq_in_if  req_if ();
  mpsq_out_if rsp_if ();

  min_priority_slot_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // queue contents as the block should hold them
  logic [VALUE_W-1:0] slot_value [SLOTS];
  logic [SLOTS-1:0]   slot_live;
  int                 held_count;
  int                 min_slot;

  resp_t awaited_responses [$];
  int    fail_count;
  int    cycle_count;
  int    burst_left;
  int    op_seen [4];
  int    refused_full;
  int    refused_empty;
  int    full_hits;
  int    responses_seen;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic resp_t apply_access(input op_e op, input logic [VALUE_W-1:0] value);
    resp_t r;
    int    best;
    r = NO_CHECK;
    case (op)
      OP_ENQUEUE: begin
        if (held_count >= SLOTS) begin
          r.status = ST_FULL;
        end else if (held_count == 0) begin
          slot_value[LAST_SLOT] = value;
          slot_live[LAST_SLOT]  = 1'b1;
          min_slot              = LAST_SLOT;
          held_count            = 1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_live[i]) begin
              slot_value[i] = value;
              slot_live[i]  = 1'b1;
              held_count++;
              if (value < slot_value[min_slot]) min_slot = i;
              break;
            end
          end
        end
      end
      OP_DEQUEUE: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_value      = slot_value[min_slot];
          slot_live[min_slot] = 1'b0;
          held_count--;
          min_slot = LAST_SLOT;
          best     = -1;
          // lowest index wins among equal minima
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && (best < 0 || int'(slot_value[i]) < best)) begin
              best     = int'(slot_value[i]);
              min_slot = i;
            end
          end
        end
      end
      OP_CLEAR: begin
        slot_live  = '0;
        held_count = 0;
        min_slot   = LAST_SLOT;
      end
      default: ;
    endcase
    r.now_empty = (held_count == 0);
    r.now_full  = (held_count >= SLOTS);
    return r;
  endfunction

  task automatic send_request(input op_e op, input logic [VALUE_W-1:0] value,
                              input logic typed, input resp_t typed_exp);
    resp_t predicted;
    int    gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= value;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted = apply_access(op, value);
    awaited_responses.push_back(typed ? typed_exp : predicted);
    op_seen[int'(op)]++;
    if (predicted.status == ST_FULL)  refused_full++;
    if (predicted.status == ST_EMPTY) refused_empty++;
    if (predicted.now_full)           full_hits++;
    burst_left--;
    @(negedge clk_i);
  endtask

  function automatic op_e pick_op(input traffic_e mode);
    int roll;
    roll = $urandom_range(0, 63);
    case (mode)
      MODE_FILL:  return (roll < 58) ? OP_ENQUEUE : (roll < 63) ? OP_DEQUEUE : OP_NOP;
      MODE_DRAIN: return (roll < 54) ? OP_DEQUEUE : (roll < 62) ? OP_ENQUEUE :
                         (roll < 63) ? OP_NOP : OP_CLEAR;
      MODE_MIXED: return (roll < 30) ? OP_ENQUEUE : (roll < 60) ? OP_DEQUEUE :
                         (roll < 62) ? OP_NOP : OP_CLEAR;
      default:    return op_e'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input value_style_e style);
    case (style)
      VAL_NARROW:   return VALUE_W'($urandom_range(0, 15));
      VAL_EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return VALUE_W'(1);
          default: return VALUE_W'($urandom_range(0, 65535));
        endcase
      end
      default:      return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : response_check
    resp_t exp_r;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      responses_seen++;
      if (awaited_responses.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        exp_r = awaited_responses.pop_front();
        check_field("result_value", exp_r.result_value, rsp_if.result_value);
        check_field("status", exp_r.status, rsp_if.status);
        check_field("now_empty", exp_r.now_empty, rsp_if.now_empty);
        check_field("now_full", exp_r.now_full, rsp_if.now_full);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               awaited_responses.size());
      $display("[min_priority_slot_queue] ERROR");
      $finish;
    end
  end

  // receiver: alternates free-flowing and choppy stretches
  initial begin : receiver
    int  stall_left;
    int  phase_cycles;
    int  phase_len;
    bit  choppy;
    stall_left   = 0;
    phase_cycles = 0;
    phase_len    = 300;
    choppy       = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (choppy && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        rsp_if.ready <= 1'b1;
      end
      phase_cycles++;
      if (phase_cycles >= phase_len) begin
        choppy       = !choppy;
        phase_cycles = 0;
        phase_len    = $urandom_range(50, 600);
      end
    end
  end

  initial begin : stimulus
    traffic_e     mode;
    value_style_e style;
    int           remaining;
    int           seg_len;
    int           segment;
    op_e          op;
    req_if.valid     = 1'b0;
    req_if.operation = OP_NOP;
    req_if.value     = '0;
    rst_ni           = 1'b0;
    slot_value       = '{default: '0};
    slot_live        = '0;
    held_count       = 0;
    min_slot         = LAST_SLOT;
    fail_count       = 0;
    cycle_count      = 0;
    burst_left       = 0;
    op_seen          = '{default: 0};
    refused_full     = 0;
    refused_empty    = 0;
    full_hits        = 0;
    responses_seen   = 0;
    remaining        = RANDOM_REQUESTS;
    segment          = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[i]) send_request(script[i].op, script[i].value, script[i].typed,
                                     script[i].exp);

    // first segment is fill traffic, mostly enqueues, to drive the queue toward capacity
    while (remaining > 0) begin
      mode    = (segment == 0) ? MODE_FILL : traffic_e'($urandom_range(0, 3));
      style   = value_style_e'($urandom_range(0, 2));
      seg_len = (mode == MODE_FILL) ? $urandom_range(70, 120) : $urandom_range(20, 100);
      for (int k = 0; k < seg_len && remaining > 0; k++) begin
        op = pick_op(mode);
        send_request(op, pick_value(style), 1'b0, NO_CHECK);
        remaining--;
      end
      segment++;
    end
    req_if.valid <= 1'b0;

    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("requests: %0d enqueue, %0d dequeue, %0d clear, %0d unused code; %0d responses",
             op_seen[OP_ENQUEUE], op_seen[OP_DEQUEUE], op_seen[OP_CLEAR], op_seen[OP_NOP],
             responses_seen);
    $display("refused full %0d, refused empty %0d, accesses leaving queue full %0d",
             refused_full, refused_empty, full_hits);
    if (fail_count == 0) begin
      $display("[min_priority_slot_queue] OK");
    end else begin
      $display("[min_priority_slot_queue] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/mpsq_pkg.sv
rtl/mpsq_in_if.sv
rtl/mpsq_out_if.sv
rtl/mpsq_sequencer.sv
rtl/mpsq_datapath.sv
rtl/min_priority_slot_queue.sv
bench/testbench.sv
